// ----- rtl/dual_servo_slew_pulse_mapper_defines.svh -----
// Assertion macros for the dual servo slew and pulse mapper.
// Included by the top level only; depends on nothing else.
`ifndef DUAL_SERVO_SLEW_PULSE_MAPPER_DEFINES_SVH
`define DUAL_SERVO_SLEW_PULSE_MAPPER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define DSSP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dssp: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define DSSP_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dssp: next-cycle check failed");

`endif

// ----- rtl/dssp_pkg.sv -----
// Shared widths, codes, sequencer states and control struct for the servo mapper.
// Used by dssp_divider, dssp_ctrl and the top level; depends on nothing.
package dssp_pkg;

   // Field and datapath widths.
   localparam int ANGLE_W   = 13;
   localparam int IN_W      = 14;
   localparam int PULSE_W   = 15;
   localparam int FUNC_W    = 2;
   localparam int CSR_IDX_W = 3;
   localparam int SPAN_W    = PULSE_W + 1;
   localparam int PROD_W    = ANGLE_W + PULSE_W;
   localparam int DVD_W     = PROD_W + 2;
   localparam int DVS_W     = ANGLE_W + 1;
   localparam int QUO_W     = PULSE_W;
   localparam int REM_W     = DVD_W - QUO_W;
   localparam int CNT_W     = 4;

   // Command codes carried in the func field.
   typedef enum logic [FUNC_W-1:0] {
      FUNC_TARGETS = 2'd0,
      FUNC_TICK    = 2'd1,
      FUNC_JUMP    = 2'd2
   } func_type;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PULSE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PULSE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ANGLE_A = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ANGLE_B = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_A      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_B      = 3'd5;

   // Sequencer states: idle, then multiply, divider load and divide for each channel, then output.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_A,
      ST_DST_A,
      ST_DIV_A,
      ST_MUL_B,
      ST_DST_B,
      ST_DIV_B,
      ST_OUT
   } state_type;

   // Strobes from the sequencer to the datapath.
   typedef struct packed {
      logic mul_en;
      logic div_start;
      logic chan_b;
      logic pulse_we;
      logic rsp_load;
   } ctrl_type;

endpackage

// ----- rtl/dssp_divider.sv -----
// Restoring serial divider, one quotient bit per cycle, shared by both channels.
// Depends on dssp_pkg for its widths.
module dssp_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [dssp_pkg::DVD_W-1:0]  dividend,
   input  logic [dssp_pkg::DVS_W-1:0]  divisor,
   output logic                        busy,
   output logic [dssp_pkg::QUO_W-1:0]  quotient
);
   import dssp_pkg::*;

   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QUO_W - 1);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0] dvd_ff, dvd_in;
   logic [REM_W:0]   trial;
   logic [REM_W:0]   diff;
   logic             fits;

   // The quotient is known to fit QUO_W bits, so the upper dividend bits
   // seed the remainder and only QUO_W steps are needed.
   always_comb begin
      trial = {rem_ff, dvd_ff[QUO_W-1]};
      fits  = trial >= (REM_W+1)'(divisor);
      diff  = trial - (REM_W+1)'(divisor);
   end

   // Next values of the iteration registers.
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = dividend[DVD_W-1:QUO_W];
         dvd_in  = dividend[QUO_W-1:0];
      end else if (busy_ff) begin
         rem_in  = fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
         dvd_in  = {dvd_ff[QUO_W-2:0], fits};
         cnt_in  = cnt_ff + 1'b1;
         busy_in = (cnt_ff != LAST_STEP);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
   end

   assign busy     = busy_ff;
   assign quotient = dvd_ff;

endmodule

// ----- rtl/dssp_ctrl.sv -----
// Sequencer that runs the shared multiplier and divider for channel A, then B.
// Depends on dssp_pkg for the state enum and the control struct.
module dssp_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               div_busy,
   input  logic               rsp_free,
   output logic               req_ready,
   output dssp_pkg::ctrl_type ctrl
);
   import dssp_pkg::*;

   state_type state_ff, state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_MUL_A;
         ST_MUL_A: state_in = ST_DST_A;
         ST_DST_A: state_in = ST_DIV_A;
         ST_DIV_A: if (!div_busy) state_in = ST_MUL_B;
         ST_MUL_B: state_in = ST_DST_B;
         ST_DST_B: state_in = ST_DIV_B;
         ST_DIV_B: if (!div_busy) state_in = ST_OUT;
         ST_OUT:   if (rsp_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Outputs for each state.
   always_comb begin
      req_ready      = 1'b0;
      ctrl           = '0;
      case (state_ff)
         ST_IDLE:  req_ready = 1'b1;
         ST_MUL_A: ctrl.mul_en = 1'b1;
         ST_DST_A: ctrl.div_start = 1'b1;
         ST_DIV_A: ctrl.pulse_we = !div_busy;
         ST_MUL_B: begin
            ctrl.chan_b = 1'b1;
            ctrl.mul_en = 1'b1;
         end
         ST_DST_B: begin
            ctrl.chan_b    = 1'b1;
            ctrl.div_start = 1'b1;
         end
         ST_DIV_B: begin
            ctrl.chan_b   = 1'b1;
            ctrl.pulse_we = !div_busy;
         end
         ST_OUT:   ctrl.rsp_load = rsp_free;
         default:  req_ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/dual_servo_slew_pulse_mapper.sv -----
// Two-channel servo slew limiter with pulse-width mapping. Each accepted word
// (set targets, tick, or jump) updates the positions and targets in the cycle
// it is accepted and then returns one word with both angles, both pulse widths
// and the moving flag. The two pulse mappings run one after the other through
// a single 13x15 multiplier and a 15-step serial divider, and the result is
// then loaded into the result register. A new word is accepted only once the
// last result has been loaded. The result register lets the next word be
// accepted while a result waits.
`include "dual_servo_slew_pulse_mapper_defines.svh"

module dual_servo_slew_pulse_mapper (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [dssp_pkg::FUNC_W-1:0]     req_func,
   input  logic signed [dssp_pkg::IN_W-1:0] req_angle_in_a,
   input  logic signed [dssp_pkg::IN_W-1:0] req_angle_in_b,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [dssp_pkg::ANGLE_W-1:0]    rsp_angle_out_a,
   output logic [dssp_pkg::ANGLE_W-1:0]    rsp_angle_out_b,
   output logic [dssp_pkg::PULSE_W-1:0]    rsp_pulse_a,
   output logic [dssp_pkg::PULSE_W-1:0]    rsp_pulse_b,
   output logic                            rsp_moving,
   input  logic                            csr_we,
   input  logic [dssp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dssp_pkg::PULSE_W-1:0]    csr_wdata
);
   import dssp_pkg::*;

   // Clamp a signed input angle to zero and the channel limit.
   function automatic logic [ANGLE_W-1:0] clamp_angle(logic [IN_W-1:0] a,
                                                      logic [ANGLE_W-1:0] lim);
      logic [ANGLE_W-1:0] r;
      if (a[IN_W-1]) begin
         r = '0;
      end else if (a[ANGLE_W-1:0] > lim) begin
         r = lim;
      end else begin
         r = a[ANGLE_W-1:0];
      end
      return r;
   endfunction

   // Move one step toward the target without passing it; a zero step jumps.
   function automatic logic [ANGLE_W-1:0] step_toward(logic [ANGLE_W-1:0] cur,
                                                      logic [ANGLE_W-1:0] tgt,
                                                      logic [ANGLE_W-1:0] step);
      logic [ANGLE_W-1:0] delta;
      logic [ANGLE_W-1:0] r;
      delta = (tgt >= cur) ? (tgt - cur) : (cur - tgt);
      if (step == '0 || delta <= step) begin
         r = tgt;
      end else if (tgt > cur) begin
         r = cur + step;
      end else begin
         r = cur - step;
      end
      return r;
   endfunction

   ctrl_type             ctrl;
   logic                 accept;
   logic                 rsp_free;
   logic                 div_busy;
   logic [QUO_W-1:0]     div_quo;
   logic [DVD_W-1:0]     div_dvd;
   logic [DVS_W-1:0]     div_dvs;

   logic [PULSE_W-1:0]   min_pulse_ff, max_pulse_ff;
   logic [ANGLE_W-1:0]   max_angle_a_ff, max_angle_b_ff;
   logic [ANGLE_W-1:0]   step_a_ff, step_b_ff;

   logic [ANGLE_W-1:0]   pos_a_ff, pos_a_in, pos_b_ff, pos_b_in;
   logic [ANGLE_W-1:0]   tgt_a_ff, tgt_a_in, tgt_b_ff, tgt_b_in;
   logic                 moving_ff, moving_in;
   logic [ANGLE_W-1:0]   clamp_a, clamp_b, next_a, next_b;

   logic [ANGLE_W-1:0]   sel_pos, sel_lim, sel_ang;
   logic [SPAN_W-1:0]    span;
   logic                 span_neg;
   logic [PULSE_W-1:0]   span_mag;
   logic [PROD_W-1:0]    prod_ff;
   logic [PROD_W:0]      prod_x2;
   logic [PULSE_W-1:0]   pulse_val;
   logic [PULSE_W-1:0]   pulse_a_ff, pulse_b_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ANGLE_W-1:0]   rsp_ang_a_ff, rsp_ang_b_ff;
   logic [PULSE_W-1:0]   rsp_pul_a_ff, rsp_pul_b_ff;
   logic                 rsp_mov_ff;

   assign accept   = req_valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_pulse_ff   <= PULSE_W'(500);
         max_pulse_ff   <= PULSE_W'(2500);
         max_angle_a_ff <= ANGLE_W'(4320);
         max_angle_b_ff <= ANGLE_W'(2880);
         step_a_ff      <= ANGLE_W'(16);
         step_b_ff      <= ANGLE_W'(16);
      end else if (csr_we) begin
         case (csr_index)
            CSR_MIN_PULSE:   min_pulse_ff   <= csr_wdata;
            CSR_MAX_PULSE:   max_pulse_ff   <= csr_wdata;
            CSR_MAX_ANGLE_A: max_angle_a_ff <= csr_wdata[ANGLE_W-1:0];
            CSR_MAX_ANGLE_B: max_angle_b_ff <= csr_wdata[ANGLE_W-1:0];
            CSR_STEP_A:      step_a_ff      <= csr_wdata[ANGLE_W-1:0];
            CSR_STEP_B:      step_b_ff      <= csr_wdata[ANGLE_W-1:0];
            default:         min_pulse_ff   <= min_pulse_ff;
         endcase
      end
   end

   // Position and target update, applied at the edge that accepts the word.
   always_comb begin
      clamp_a   = clamp_angle(req_angle_in_a, max_angle_a_ff);
      clamp_b   = clamp_angle(req_angle_in_b, max_angle_b_ff);
      next_a    = step_toward(pos_a_ff, tgt_a_ff, step_a_ff);
      next_b    = step_toward(pos_b_ff, tgt_b_ff, step_b_ff);
      pos_a_in  = pos_a_ff;
      pos_b_in  = pos_b_ff;
      tgt_a_in  = tgt_a_ff;
      tgt_b_in  = tgt_b_ff;
      moving_in = moving_ff;
      if (accept) begin
         moving_in = 1'b0;
         case (func_type'(req_func))
            FUNC_TARGETS: begin
               tgt_a_in = clamp_a;
               tgt_b_in = clamp_b;
            end
            FUNC_TICK: begin
               pos_a_in  = next_a;
               pos_b_in  = next_b;
               moving_in = (next_a != pos_a_ff) || (next_b != pos_b_ff);
            end
            FUNC_JUMP: begin
               tgt_a_in = clamp_a;
               tgt_b_in = clamp_b;
               pos_a_in = clamp_a;
               pos_b_in = clamp_b;
            end
            default: moving_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_a_ff  <= '0;
         pos_b_ff  <= '0;
         tgt_a_ff  <= '0;
         tgt_b_ff  <= '0;
         moving_ff <= 1'b0;
      end else begin
         pos_a_ff  <= pos_a_in;
         pos_b_ff  <= pos_b_in;
         tgt_a_ff  <= tgt_a_in;
         tgt_b_ff  <= tgt_b_in;
         moving_ff <= moving_in;
      end
   end

   // Channel operands and the signed pulse span.
   always_comb begin
      sel_pos  = ctrl.chan_b ? pos_b_ff : pos_a_ff;
      sel_lim  = ctrl.chan_b ? max_angle_b_ff : max_angle_a_ff;
      sel_ang  = (sel_pos > sel_lim) ? sel_lim : sel_pos;
      span     = {1'b0, max_pulse_ff} - {1'b0, min_pulse_ff};
      span_neg = span[SPAN_W-1];
      span_mag = span_neg ? PULSE_W'(~span + 1'b1) : span[PULSE_W-1:0];
   end

   // Shared multiplier: clamped angle times the span magnitude.
   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= sel_ang * span_mag;
      end
   end

   // Rounded dividend 2*a*span + lim over divisor 2*lim.
   assign prod_x2 = {prod_ff, 1'b0};
   assign div_dvd = DVD_W'(prod_x2) + DVD_W'(sel_lim);
   assign div_dvs = {sel_lim, 1'b0};

   dssp_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctrl.div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   // Final pulse. A zero channel limit gives the lower limit. With a negative
   // span the result is one of the two limits, chosen by the sign of the rounded
   // numerator; otherwise it never passes the upper limit.
   always_comb begin
      if (sel_lim == '0) begin
         pulse_val = min_pulse_ff;
      end else if (span_neg) begin
         pulse_val = (prod_x2 > (PROD_W+1)'(sel_lim)) ? min_pulse_ff : max_pulse_ff;
      end else begin
         pulse_val = min_pulse_ff + div_quo;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.pulse_we) begin
         if (ctrl.chan_b) begin
            pulse_b_ff <= pulse_val;
         end else begin
            pulse_a_ff <= pulse_val;
         end
      end
   end

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (ctrl.rsp_load) begin
         rsp_ang_a_ff <= pos_a_ff;
         rsp_ang_b_ff <= pos_b_ff;
         rsp_pul_a_ff <= pulse_a_ff;
         rsp_pul_b_ff <= pulse_b_ff;
         rsp_mov_ff   <= moving_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_angle_out_a = rsp_ang_a_ff;
   assign rsp_angle_out_b = rsp_ang_b_ff;
   assign rsp_pulse_a     = rsp_pul_a_ff;
   assign rsp_pulse_b     = rsp_pul_b_ff;
   assign rsp_moving      = rsp_mov_ff;

   dssp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .div_busy  (div_busy),
      .rsp_free  (rsp_free),
      .req_ready (req_ready),
      .ctrl      (ctrl)
   );

   // Sequencing checks.
   `DSSP_ASSERT_NXT(a_busy_after_accept, clock, reset, accept, !req_ready)
   `DSSP_ASSERT_IMP(a_start_when_idle, clock, reset, ctrl.div_start, !div_busy)
   `DSSP_ASSERT_IMP(a_pulse_after_divide, clock, reset, ctrl.pulse_we, !div_busy)
   `DSSP_ASSERT_IMP(a_load_into_free, clock, reset, ctrl.rsp_load, rsp_free)

endmodule
